[hdl/cabt_pkg.sv]
`timescale 1ns / 1ps

package cabt_pkg;

  // shared divider geometry
  localparam int DIV_W      = 32;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_BITS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUN_BITS = 2'd2;

  localparam logic [7:0]  TICKS_PER_US_RESET = 8'd60;
  localparam logic [5:0]  GAP_BITS_RESET     = 6'd12;
  localparam logic [5:0]  MAX_RUN_RESET      = 6'd6;
  localparam logic [15:0] MIN_BIT_TIME_RESET = 16'hFFFF;
  localparam logic [DIV_W-1:0] BAUD_NUMERATOR = 32'd1000000;

  typedef struct packed {
    logic [15:0] capture_value;
    logic [15:0] overflow_count;
  } in_item_t;

  typedef struct packed {
    logic        width_valid;
    logic [31:0] pulse_us;
    logic [15:0] bit_time_us;
    logic [19:0] baud_rate;
    logic [7:0]  bit_count;
    logic        pulse_level;
    logic        frame_gap;
    logic        in_frame;
    logic        stuff_error;
    logic        zero_bit_time;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIDTH,
    ST_US_GO,
    ST_US_WAIT,
    ST_ROUND,
    ST_MIN,
    ST_BITS_GO,
    ST_BITS_WAIT,
    ST_BAUD_GO,
    ST_BAUD_WAIT,
    ST_GAP,
    ST_FINISH
  } state_t;

endpackage

[hdl/cabt_div.sv]
`timescale 1ns / 1ps

module cabt_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [cabt_pkg::DIV_W-1:0]          dividend,
  input  logic [cabt_pkg::DIVISOR_W-1:0]      divisor,
  output logic [cabt_pkg::DIV_W-1:0]          quotient,
  output logic [cabt_pkg::DIVISOR_W-1:0]      remainder,
  output cabt_pkg::div_stat_t                 stat
);

  logic                              busy_r;
  logic                              done_r;
  logic [cabt_pkg::DIV_CNT_W-1:0]    cnt_r;
  logic [cabt_pkg::DIV_W-1:0]        quo_r;
  logic [cabt_pkg::DIVISOR_W-1:0]    rem_r;
  logic [cabt_pkg::DIVISOR_W-1:0]    dsr_r;

  logic [cabt_pkg::DIVISOR_W:0]      trial;
  logic [cabt_pkg::DIVISOR_W:0]      diff;
  logic                              take;

  // one restoring step per cycle, msb first
  always_comb begin
    trial = {rem_r, quo_r[cabt_pkg::DIV_W-1]};
    diff  = trial - {1'b0, dsr_r};
    take  = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + cabt_pkg::DIV_CNT_W'(1);
        if (cnt_r == cabt_pkg::DIV_CNT_W'(cabt_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      // a failed trial is below the divisor, so it fits the remainder
      rem_r <= take ? diff[cabt_pkg::DIVISOR_W-1:0] : trial[cabt_pkg::DIVISOR_W-1:0];
      quo_r <= {quo_r[cabt_pkg::DIV_W-2:0], take};
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat      = '{busy: busy_r, done: done_r};

endmodule

[hdl/can_autobaud_edge_timer.sv]
`timescale 1ns / 1ps

// CAN auto-baud edge timer. Each request is one bus edge: a 16-bit timer capture and the
// overflows seen since the last edge. The block measures the pulse since the previous edge,
// converts it to microseconds (rounded up only above one half), keeps the smallest pulse as
// the bit time, and reports the baud rate, bits in the pulse, gap, level and stuffing flags.
// A measured edge makes up to three 32-step passes through the single shared restoring
// divider (ticks to microseconds, pulse to bits, one million to baud rate); the first edge
// after reset makes only the baud pass, and a measured edge once the bit time is zero only
// the microsecond pass. The next request is taken as soon as the sequencer is idle, even
// while a result still waits in the output register. Configuration writes take effect at
// once and should be made idle.
module can_autobaud_edge_timer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cabt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cabt_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [cabt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cabt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  cabt_pkg::state_t state_r, state_nxt;

  // configuration
  logic [7:0]  tpu_r;
  logic [5:0]  gap_bits_r;
  logic [5:0]  max_run_r;

  // edge state
  logic [15:0] prev_r;
  logic        have_prev_r;
  logic [15:0] min_r;
  logic        next_level_r;
  logic        frame_r;

  // per-request working registers
  logic [15:0] cap_r;
  logic [15:0] ovf_r;
  logic        meas_r;
  logic [31:0] ticks_r;
  logic [31:0] pulse_r;
  logic [7:0]  bits_r;
  logic [19:0] baud_r;
  logic [21:0] prod_r;

  logic                 out_valid_r;
  cabt_pkg::out_item_t  out_r;

  // divider
  logic                                div_start;
  logic [cabt_pkg::DIV_W-1:0]          div_dividend;
  logic [cabt_pkg::DIVISOR_W-1:0]      div_divisor;
  logic [cabt_pkg::DIV_W-1:0]          div_q;
  logic [cabt_pkg::DIVISOR_W-1:0]      div_rem;
  cabt_pkg::div_stat_t                 div_stat;

  logic        accept;
  logic        out_load;
  logic [7:0]  tpu_eff;
  logic [15:0] ticks_hi;
  logic        round_up;
  logic [32:0] pulse_sum;
  logic        gap;
  logic        level;
  logic        stuff;

  cabt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_q),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cabt_pkg::ST_IDLE:      if (in_valid) state_nxt = cabt_pkg::ST_WIDTH;
      cabt_pkg::ST_WIDTH: begin
        if (have_prev_r) state_nxt = cabt_pkg::ST_US_GO;
        else if (min_r != 16'd0) state_nxt = cabt_pkg::ST_BAUD_GO;
        else state_nxt = cabt_pkg::ST_FINISH;
      end
      cabt_pkg::ST_US_GO:     state_nxt = cabt_pkg::ST_US_WAIT;
      cabt_pkg::ST_US_WAIT:   if (div_stat.done) state_nxt = cabt_pkg::ST_ROUND;
      cabt_pkg::ST_ROUND:     state_nxt = cabt_pkg::ST_MIN;
      cabt_pkg::ST_MIN:       state_nxt = cabt_pkg::ST_BITS_GO;
      cabt_pkg::ST_BITS_GO: begin
        state_nxt = (min_r != 16'd0) ? cabt_pkg::ST_BITS_WAIT : cabt_pkg::ST_GAP;
      end
      cabt_pkg::ST_BITS_WAIT: if (div_stat.done) state_nxt = cabt_pkg::ST_BAUD_GO;
      cabt_pkg::ST_BAUD_GO:   state_nxt = cabt_pkg::ST_BAUD_WAIT;
      cabt_pkg::ST_BAUD_WAIT: begin
        if (div_stat.done) state_nxt = meas_r ? cabt_pkg::ST_GAP : cabt_pkg::ST_FINISH;
      end
      cabt_pkg::ST_GAP:       state_nxt = cabt_pkg::ST_FINISH;
      cabt_pkg::ST_FINISH:    if (out_load) state_nxt = cabt_pkg::ST_IDLE;
      default:                state_nxt = cabt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = ticks_r;
    div_divisor  = {8'd0, tpu_eff};
    out_load     = 1'b0;
    case (state_r)
      cabt_pkg::ST_IDLE:    in_ready = 1'b1;
      cabt_pkg::ST_US_GO:   div_start = 1'b1;
      cabt_pkg::ST_BITS_GO: begin
        div_start    = (min_r != 16'd0);
        div_dividend = pulse_r;
        div_divisor  = min_r;
      end
      cabt_pkg::ST_BAUD_GO: begin
        div_start    = 1'b1;
        div_dividend = cabt_pkg::BAUD_NUMERATOR;
        div_divisor  = min_r;
      end
      cabt_pkg::ST_FINISH:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept  = in_valid && in_ready;
  assign tpu_eff = (tpu_r == 8'd0) ? 8'd1 : tpu_r;

  // equal or lower capture without overflow counts one hidden wrap
  assign ticks_hi = ((ovf_r == 16'd0) && (cap_r <= prev_r)) ? 16'd1 : ovf_r;

  assign round_up  = ({div_rem, 1'b0} > {9'd0, tpu_eff});
  assign pulse_sum = {1'b0, div_q} + {32'd0, round_up};

  always_comb begin
    gap   = meas_r && (pulse_r >= {10'd0, prod_r});
    level = 1'b0;
    stuff = 1'b0;
    if (meas_r && !gap && frame_r) begin
      level = next_level_r;
      stuff = (bits_r > {2'b00, max_run_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cabt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r      <= cabt_pkg::TICKS_PER_US_RESET;
      gap_bits_r <= cabt_pkg::GAP_BITS_RESET;
      max_run_r  <= cabt_pkg::MAX_RUN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cabt_pkg::CFG_TICKS_PER_US: tpu_r      <= cfg_wdata;
        cabt_pkg::CFG_GAP_BITS:     gap_bits_r <= cfg_wdata[5:0];
        cabt_pkg::CFG_MAX_RUN_BITS: max_run_r  <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // edge state that persists across requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r       <= '0;
      have_prev_r  <= 1'b0;
      min_r        <= cabt_pkg::MIN_BIT_TIME_RESET;
      next_level_r <= 1'b0;
      frame_r      <= 1'b0;
    end else begin
      if ((state_r == cabt_pkg::ST_MIN) && (pulse_r < {16'd0, min_r})) begin
        min_r <= pulse_r[15:0];
      end
      if (out_load) begin
        prev_r      <= cap_r;
        have_prev_r <= 1'b1;
        if (gap) begin
          frame_r      <= 1'b1;
          next_level_r <= 1'b0;
        end else if (meas_r && frame_r) begin
          next_level_r <= ~next_level_r;
        end
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      cap_r <= in_data.capture_value;
      ovf_r <= in_data.overflow_count;
    end
    case (state_r)
      cabt_pkg::ST_WIDTH: begin
        meas_r  <= have_prev_r;
        ticks_r <= {ticks_hi, cap_r} - {16'd0, prev_r};
        pulse_r <= '0;
        bits_r  <= '0;
        baud_r  <= '0;
        prod_r  <= '0;
      end
      cabt_pkg::ST_ROUND: begin
        pulse_r <= pulse_sum[32] ? 32'hFFFF_FFFF : pulse_sum[31:0];
      end
      cabt_pkg::ST_BITS_WAIT: begin
        if (div_stat.done) begin
          bits_r <= (div_q > 32'd255) ? 8'd255 : div_q[7:0];
        end
      end
      cabt_pkg::ST_BAUD_WAIT: begin
        if (div_stat.done) baud_r <= div_q[19:0];
      end
      cabt_pkg::ST_GAP: begin
        prod_r <= 22'(min_r) * 22'(gap_bits_r);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.width_valid   <= meas_r;
      out_r.pulse_us      <= pulse_r;
      out_r.bit_time_us   <= min_r;
      out_r.baud_rate     <= baud_r;
      out_r.bit_count     <= bits_r;
      out_r.pulse_level   <= level;
      out_r.frame_gap     <= gap;
      out_r.in_frame      <= frame_r;
      out_r.stuff_error   <= stuff;
      out_r.zero_bit_time <= (min_r == 16'd0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/cabt_checker.sv]
`timescale 1ns / 1ps

module cabt_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  cabt_pkg::out_item_t                 out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time through the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // first edge carries no measurement
  a_first_edge_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.width_valid |->
      out_data.pulse_us == 32'd0 && out_data.bit_count == 8'd0 &&
      !out_data.frame_gap && !out_data.stuff_error && !out_data.pulse_level)
    else $error("unmeasured edge carries data");

  a_zero_bit_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.zero_bit_time == (out_data.bit_time_us == 16'd0)) &&
      (!out_data.zero_bit_time || out_data.baud_rate == 20'd0))
    else $error("zero bit time flag inconsistent");

  a_stuff_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stuff_error |->
      out_data.in_frame && !out_data.frame_gap && out_data.width_valid)
    else $error("stuff error outside a frame");

endmodule

bind can_autobaud_edge_timer cabt_checker u_cabt_checker (.*);

[tb/can_autobaud_edge_timer_tb.sv]
`timescale 1ns / 1ps

module can_autobaud_edge_timer_tb;

  localparam int NUM_PHASES       = 10;
  localparam int EDGES_PER_PHASE  = 153;
  localparam int SETTLE_CYCLES    = 8;
  localparam int DRAIN_CYCLES     = 300;
  localparam int QUIET_LIMIT      = 20000;
  localparam int LONG_HOLD_AFTER  = 300;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int NUM_ROWS         = 24;
  localparam logic [31:0] BAUD_CONST = 32'd1000000;

  localparam cabt_pkg::out_item_t FIRST_EDGE_RESULT = '{
    width_valid: 1'b0, pulse_us: 32'd0, bit_time_us: 16'hFFFF, baud_rate: 20'd15,
    bit_count: 8'd0, pulse_level: 1'b0, frame_gap: 1'b0, in_frame: 1'b0,
    stuff_error: 1'b0, zero_bit_time: 1'b0};
  localparam cabt_pkg::out_item_t ZERO_BIT_RESULT = '{
    width_valid: 1'b1, pulse_us: 32'd0, bit_time_us: 16'd0, baud_rate: 20'd0,
    bit_count: 8'd0, pulse_level: 1'b0, frame_gap: 1'b1, in_frame: 1'b1,
    stuff_error: 1'b0, zero_bit_time: 1'b1};

  typedef enum logic [1:0] {ROW_RAW, ROW_TICKS, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                        kind;
    logic [cabt_pkg::CFG_IDX_W-1:0]   reg_sel;
    logic [31:0]                      arg;
    logic [15:0]                      ovf;
    bit                               typed;
    bit                               at_end;
    cabt_pkg::out_item_t              result;
  } edge_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  cabt_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  cabt_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [cabt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cabt_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // predictor copy of the registers and state
  logic [7:0]  cfg_ticks    = cabt_pkg::TICKS_PER_US_RESET;
  logic [5:0]  cfg_gap      = cabt_pkg::GAP_BITS_RESET;
  logic [5:0]  cfg_run      = cabt_pkg::MAX_RUN_RESET;
  logic [15:0] cap_prev     = 16'd0;
  logic        edge_seen    = 1'b0;
  logic [15:0] bit_time_min = cabt_pkg::MIN_BIT_TIME_RESET;
  logic        level_next   = 1'b0;
  logic        frame_open   = 1'b0;

  cabt_pkg::out_item_t pulse_reports_due[$];
  logic [15:0] prev_sent = 16'd0;

  int errors          = 0;
  int edges_sent      = 0;
  int results_checked = 0;
  int regs_written    = 0;
  int gaps_seen       = 0;
  int stuff_seen      = 0;
  int zero_seen       = 0;

  edge_row_t edge_rows [NUM_ROWS] = '{
    '{ROW_RAW,   cabt_pkg::CFG_TICKS_PER_US, 32'h0000, 16'h0000, 1'b1, 1'b0, FIRST_EDGE_RESULT},
    '{ROW_RAW,   cabt_pkg::CFG_TICKS_PER_US, 32'h0000, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_RAW,   cabt_pkg::CFG_TICKS_PER_US, 32'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
    '{ROW_RAW,   cabt_pkg::CFG_TICKS_PER_US, 32'hFFFF, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_CFG,   cabt_pkg::CFG_TICKS_PER_US, 32'd0,    16'h0000, 1'b0, 1'b0, '0},
    '{ROW_RAW,   cabt_pkg::CFG_TICKS_PER_US, 32'h7FFF, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_CFG,   cabt_pkg::CFG_TICKS_PER_US, 32'd255,  16'h0000, 1'b0, 1'b0, '0},
    '{ROW_TICKS, cabt_pkg::CFG_TICKS_PER_US, 32'd65537, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_CFG,   cabt_pkg::CFG_TICKS_PER_US, 32'd60,   16'h0000, 1'b0, 1'b0, '0},
    '{ROW_TICKS, cabt_pkg::CFG_TICKS_PER_US, 32'd18030, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_TICKS, cabt_pkg::CFG_TICKS_PER_US, 32'd18031, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_TICKS, cabt_pkg::CFG_TICKS_PER_US, 32'd123360, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_CFG,   cabt_pkg::CFG_GAP_BITS,     32'd63,   16'h0000, 1'b0, 1'b0, '0},
    '{ROW_CFG,   cabt_pkg::CFG_MAX_RUN_BITS, 32'd1,    16'h0000, 1'b0, 1'b0, '0},
    '{ROW_TICKS, cabt_pkg::CFG_TICKS_PER_US, 32'd30840, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_TICKS, cabt_pkg::CFG_TICKS_PER_US, 32'd616800, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_CFG,   cabt_pkg::CFG_GAP_BITS,     32'd1,    16'h0000, 1'b0, 1'b0, '0},
    '{ROW_TICKS, cabt_pkg::CFG_TICKS_PER_US, 32'd15420, 16'h0000, 1'b0, 1'b0, '0},
    '{ROW_CFG,   cabt_pkg::CFG_GAP_BITS,     32'd12,   16'h0000, 1'b0, 1'b0, '0},
    '{ROW_CFG,   cabt_pkg::CFG_MAX_RUN_BITS, 32'd63,   16'h0000, 1'b0, 1'b0, '0},
    '{ROW_TICKS, cabt_pkg::CFG_TICKS_PER_US, 32'd46260, 16'h0000, 1'b0, 1'b0, '0},
    // a zero bit time sticks until reset, so these close the run
    '{ROW_CFG,   cabt_pkg::CFG_TICKS_PER_US, 32'd255,  16'h0000, 1'b0, 1'b1, '0},
    '{ROW_TICKS, cabt_pkg::CFG_TICKS_PER_US, 32'd1,    16'h0000, 1'b1, 1'b1, ZERO_BIT_RESULT},
    '{ROW_TICKS, cabt_pkg::CFG_TICKS_PER_US, 32'd200000, 16'h0000, 1'b0, 1'b1, '0}
  };

  can_autobaud_edge_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cabt_pkg::out_item_t measure_edge(input cabt_pkg::in_item_t e);
    logic [63:0]         ticks, divisor, quo, rem, bt;
    cabt_pkg::out_item_t r;
    logic                was_open;
    r = '0;
    was_open = frame_open;
    if (edge_seen) begin
      if (e.overflow_count == 16'd0) begin
        // capture at or below the previous one means one unreported wrap
        ticks = (e.capture_value <= cap_prev)
              ? 64'd65536 - 64'(cap_prev) + 64'(e.capture_value)
              : 64'(e.capture_value) - 64'(cap_prev);
      end else begin
        ticks = 64'(e.overflow_count) * 64'd65536 - 64'(cap_prev) + 64'(e.capture_value);
      end
      divisor = (cfg_ticks == 8'd0) ? 64'd1 : 64'(cfg_ticks);
      quo = ticks / divisor;
      rem = ticks % divisor;
      if (2 * rem > divisor) quo = quo + 64'd1;
      if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
      r.width_valid = 1'b1;
      r.pulse_us = quo[31:0];
      if (quo < 64'(bit_time_min)) bit_time_min = quo[15:0];
      bt = 64'(bit_time_min);
      if (bt != 64'd0) r.bit_count = (quo / bt > 64'd255) ? 8'd255 : 8'(quo / bt);
      r.frame_gap = (quo >= bt * 64'(cfg_gap));
      if (r.frame_gap) begin
        frame_open = 1'b1;
        level_next = 1'b0;
      end else if (was_open) begin
        r.pulse_level = level_next;
        level_next = ~level_next;
        r.stuff_error = (r.bit_count > 8'(cfg_run));
      end
    end
    cap_prev = e.capture_value;
    edge_seen = 1'b1;
    r.bit_time_us = bit_time_min;
    r.baud_rate = (bit_time_min != 16'd0) ? 20'(BAUD_CONST / 32'(bit_time_min)) : 20'd0;
    r.in_frame = was_open;
    r.zero_bit_time = (bit_time_min == 16'd0);
    return r;
  endfunction

  // edge that lies the given number of ticks after the last one sent
  function automatic cabt_pkg::in_item_t make_edge(input logic [31:0] ticks,
                                                   input bit wrap_ok);
    logic [47:0]        sum;
    cabt_pkg::in_item_t e;
    sum = 48'(prev_sent) + 48'(ticks);
    e.capture_value = sum[15:0];
    e.overflow_count = sum[31:16];
    if (wrap_ok && sum[31:16] == 16'd1 && sum[15:0] <= prev_sent) e.overflow_count = 16'd0;
    return e;
  endfunction

  function automatic int pick_pause();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 6);
    return $urandom_range(20, 250);
  endfunction

  task automatic send_edge(input cabt_pkg::in_item_t e, input int idle, input bit typed,
                           input cabt_pkg::out_item_t typed_res);
    cabt_pkg::out_item_t want;
    if (idle > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    in_data <= e;
    in_valid <= 1'b1;
    prev_sent = e.capture_value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = measure_edge(e);
    pulse_reports_due.push_back(typed ? typed_res : want);
    edges_sent++;
  endtask

  task automatic write_reg(input logic [cabt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] value);
    @(negedge clk) in_valid <= 1'b0;
    while (pulse_reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      cabt_pkg::CFG_TICKS_PER_US: cfg_ticks = value;
      cabt_pkg::CFG_GAP_BITS:     cfg_gap = value[5:0];
      cabt_pkg::CFG_MAX_RUN_BITS: cfg_run = value[5:0];
      default: ;
    endcase
    regs_written++;
  endtask

  task automatic run_rows(input bit late_part);
    cabt_pkg::in_item_t e;
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (edge_rows[i].at_end == late_part) begin
        case (edge_rows[i].kind)
          ROW_CFG: begin
            write_reg(edge_rows[i].reg_sel, edge_rows[i].arg[7:0]);
          end
          ROW_RAW: begin
            e.capture_value = edge_rows[i].arg[15:0];
            e.overflow_count = edge_rows[i].ovf;
            send_edge(e, pick_pause(), edge_rows[i].typed, edge_rows[i].result);
          end
          default: begin
            e = make_edge(edge_rows[i].arg, 1'b0);
            send_edge(e, pick_pause(), edge_rows[i].typed, edge_rows[i].result);
          end
        endcase
      end
    end
  endtask

  initial begin : stimulus
    cabt_pkg::in_item_t e;
    logic [7:0]  tpu;
    logic [7:0]  gap_set;
    logic [7:0]  run_set;
    int unsigned bit_us, bit_ticks, jit, k, w, roll;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = cabt_pkg::CFG_TICKS_PER_US;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    run_rows(1'b0);

    // bit time only shrinks, so each phase uses a nominal bit no longer than the last
    for (int p = 0; p < NUM_PHASES; p++) begin
      tpu = (p == 1) ? 8'd255 : (p == 2 || p == NUM_PHASES - 1) ? 8'd1
          : 8'($urandom_range(1, 255));
      gap_set = (p == 3) ? 8'd63 : (p == 4) ? 8'd1 : 8'($urandom_range(3, 20));
      if (p == 3) run_set = 8'd63;
      else if (p == 5) run_set = 8'd1;
      else if (gap_set > 1) run_set = 8'($urandom_range(1, gap_set));
      else run_set = 8'($urandom_range(1, 63));
      write_reg(cabt_pkg::CFG_TICKS_PER_US, tpu);
      write_reg(cabt_pkg::CFG_GAP_BITS, gap_set);
      write_reg(cabt_pkg::CFG_MAX_RUN_BITS, run_set);
      bit_us = (p < 8) ? (240 >> p) : 1;
      bit_ticks = bit_us * tpu;
      jit = bit_ticks / 8;
      for (int i = 0; i < EDGES_PER_PHASE; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // noise: long pulse with arbitrary capture bits
          e.capture_value = 16'($urandom);
          e.overflow_count = 16'($urandom_range(2, 65535));
        end else begin
          if (roll < 68) k = $urandom_range(1, 5);
          else if (roll < 84) k = $urandom_range(1, int'(cfg_gap) + 2);
          else k = int'(cfg_gap) + $urandom_range(0, 4);
          w = k * bit_ticks - jit + $urandom_range(0, 2 * jit);
          e = make_edge(w, 1'($urandom_range(0, 1)));
        end
        send_edge(e, (p == 7) ? 0 : pick_pause(), 1'b0, '0);
      end
    end

    run_rows(1'b1);

    @(negedge clk) in_valid <= 1'b0;
    while (pulse_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d edges sent, %0d results checked, %0d register writes",
             edges_sent, results_checked, regs_written);
    $display("seen: %0d gaps, %0d stuffing errors, %0d zero bit time results",
             gaps_seen, stuff_seen, zero_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver: random stalls plus one long hold so the block backs up
  initial begin : result_sink
    int hold;
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      if (!long_hold_done && results_checked >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        @(negedge clk) out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      hold = pick_pause();
      if (hold > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  task automatic match_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    cabt_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pulse_reports_due.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = pulse_reports_due.pop_front();
        match_field("width_valid", 32'(want.width_valid), 32'(out_data.width_valid));
        match_field("pulse_us", want.pulse_us, out_data.pulse_us);
        match_field("bit_time_us", 32'(want.bit_time_us), 32'(out_data.bit_time_us));
        match_field("baud_rate", 32'(want.baud_rate), 32'(out_data.baud_rate));
        match_field("bit_count", 32'(want.bit_count), 32'(out_data.bit_count));
        match_field("pulse_level", 32'(want.pulse_level), 32'(out_data.pulse_level));
        match_field("frame_gap", 32'(want.frame_gap), 32'(out_data.frame_gap));
        match_field("in_frame", 32'(want.in_frame), 32'(out_data.in_frame));
        match_field("stuff_error", 32'(want.stuff_error), 32'(out_data.stuff_error));
        match_field("zero_bit_time", 32'(want.zero_bit_time), 32'(out_data.zero_bit_time));
      end
      results_checked++;
      if (out_data.frame_gap === 1'b1) gaps_seen++;
      if (out_data.stuff_error === 1'b1) stuff_seen++;
      if (out_data.zero_bit_time === 1'b1) zero_seen++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
hdl/cabt_pkg.sv
hdl/cabt_div.sv
hdl/can_autobaud_edge_timer.sv
hdl/cabt_checker.sv
tb/can_autobaud_edge_timer_tb.sv
